>>> hw/rtl/jbrle_pkg.sv
// ----------------------------------------------------------------------------
// jbrle_pkg
// shared types, constants and the category coding function of the
// block run-length encoder
// ----------------------------------------------------------------------------
package jbrle_pkg;

  localparam int unsigned BlockLenDef = 64;
  localparam logic [3:0]  MaxRun      = 4'd15;
  localparam logic [1:0]  MaxHeld     = 2'd3;

  // one input request
  typedef struct packed {
    logic signed [11:0] coefficient;
    logic               restart_predictor;
  } coef_req_t;

  // one result
  typedef struct packed {
    logic [3:0]  zero_run;
    logic [3:0]  category;
    logic [11:0] amplitude_bits;
    logic        block_done;
  } rle_res_t;

  // everything one request gives, before serialisation
  typedef struct packed {
    logic [1:0]  held;
    logic        main_vld;
    logic [3:0]  main_run;
    logic [3:0]  main_cat;
    logic [11:0] main_bits;
    logic        main_done;
    logic        eob_vld;
  } rle_bundle_t;

  typedef struct packed {
    logic [3:0]  cat;
    logic [11:0] bits;
  } cat_code_t;

  // bit length of the magnitude and ones-complement amplitude bits
  function automatic cat_code_t categorize(input logic signed [12:0] v);
    cat_code_t   res;
    logic [12:0] mag_w;
    logic [11:0] mag;
    logic [11:0] mask;
    mag_w = v[12] ? 13'(-v) : 13'(v);
    mag   = mag_w[11:0];
    res.cat = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (mag[i]) begin
        res.cat = 4'(i + 1);
      end
    end
    mask     = 12'((13'd1 << res.cat) - 13'd1);
    res.bits = v[12] ? (~mag & mask) : mag;
    return res;
  endfunction

endpackage

>>> hw/rtl/jpeg_block_run_length_encoder.sv
// ----------------------------------------------------------------------------
// jpeg_block_run_length_encoder
// run-length and category coding of zigzag-ordered quantized blocks
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   input   | in        | in_valid_i / in_ready_o | in_req_i  (coef_req_t)
//   result  | out       | out_valid_o/ out_ready_i| out_res_o (rle_res_t)
//
// one request a cycle is taken while each request gives at most one result
// and the result side keeps taking; a request that gives several results
// holds the input side while the result register drains
// latency: a result appears the cycle after its request is accepted
// reset clears the predictor, block position and run counters at once
// stalls on the result side hold the result register and then the input
// ----------------------------------------------------------------------------
module jpeg_block_run_length_encoder import jbrle_pkg::*; #(
  parameter int unsigned BLOCK_LEN = BlockLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  coef_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rle_res_t  out_res_o
);

  // result register: held zero runs, then the coded value, then eob
  logic [1:0]  held_q;
  logic        main_vld_q;
  logic        eob_vld_q;
  logic [3:0]  main_run_q;
  logic [3:0]  main_cat_q;
  logic [11:0] main_bits_q;
  logic        main_done_q;

  rle_bundle_t bundle;
  logic        in_fire;
  logic        out_fire;
  logic [2:0]  left;

  jbrle_coder #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_coder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .req_i    (in_req_i),
    .bundle_o (bundle)
  );

  // results still waiting in the result register
  assign left        = 3'(held_q) + 3'(main_vld_q) + 3'(eob_vld_q);
  assign out_valid_o = (left != 3'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  // take a new request when empty or when the last result leaves now
  assign in_ready_o  = !out_valid_o || (out_ready_i && left == 3'd1);
  assign in_fire     = in_valid_i && in_ready_o;

  // result selection in emission order
  always_comb begin
    out_res_o = '0;
    if (held_q != 2'd0) begin
      out_res_o.zero_run = MaxRun;
    end else if (main_vld_q) begin
      out_res_o.zero_run       = main_run_q;
      out_res_o.category       = main_cat_q;
      out_res_o.amplitude_bits = main_bits_q;
      out_res_o.block_done     = main_done_q;
    end else begin
      out_res_o.block_done = eob_vld_q;
    end
  end

  // control of the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      main_vld_q <= 1'b0;
      eob_vld_q  <= 1'b0;
    end else if (in_fire) begin
      held_q     <= bundle.held;
      main_vld_q <= bundle.main_vld;
      eob_vld_q  <= bundle.eob_vld;
    end else if (out_fire) begin
      if (held_q != 2'd0) begin
        held_q <= held_q - 2'd1;
      end else if (main_vld_q) begin
        main_vld_q <= 1'b0;
      end else begin
        eob_vld_q <= 1'b0;
      end
    end
  end

  // payload of the coded value, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      main_run_q  <= bundle.main_run;
      main_cat_q  <= bundle.main_cat;
      main_bits_q <= bundle.main_bits;
      main_done_q <= bundle.main_done;
    end
  end

endmodule

>>> hw/rtl/jbrle_coder.sv
// ----------------------------------------------------------------------------
// jbrle_coder
// block position, dc predictor and zero-run state; works out the results
// of one request in a single pass
// ----------------------------------------------------------------------------
module jbrle_coder import jbrle_pkg::*; #(
  parameter int unsigned BLOCK_LEN = BlockLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  coef_req_t   req_i,
  output rle_bundle_t bundle_o
);

  localparam int unsigned PosW = $clog2(BLOCK_LEN);
  localparam int unsigned CntW = $clog2(BLOCK_LEN + 1);

  logic signed [11:0] prev_dc_q, prev_dc_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [3:0]         zc_q, zc_d;
  logic [1:0]         held_q, held_d;
  logic [CntW-1:0]    emitted_q, emitted_d;

  logic signed [11:0] prev;
  logic signed [12:0] diff;
  logic [CntW-1:0]    emitted_new;
  cat_code_t          code;
  rle_bundle_t        b;

  always_comb begin
    prev        = req_i.restart_predictor ? 12'sd0 : prev_dc_q;
    diff        = {req_i.coefficient[11], req_i.coefficient} - {prev[11], prev};
    b           = '0;
    prev_dc_d   = prev;
    zc_d        = zc_q;
    held_d      = held_q;
    emitted_new = emitted_q;
    code        = categorize({req_i.coefficient[11], req_i.coefficient});

    if (pos_q == '0) begin
      code        = categorize(diff);
      b.main_vld  = 1'b1;
      prev_dc_d   = req_i.coefficient;
      zc_d        = 4'd0;
      held_d      = 2'd0;
      emitted_new = CntW'(1);
    end else if (req_i.coefficient == 12'sd0) begin
      if (zc_q < MaxRun) begin
        zc_d = zc_q + 4'd1;
      end else begin
        if (held_q < MaxHeld) begin
          held_d = held_q + 2'd1;
        end
        zc_d = 4'd0;
      end
    end else begin
      b.held      = held_q;
      b.main_vld  = 1'b1;
      b.main_run  = zc_q;
      emitted_new = emitted_q + CntW'(held_q) + CntW'(1);
      zc_d        = 4'd0;
      held_d      = 2'd0;
    end
    b.main_cat  = code.cat;
    b.main_bits = code.bits;

    pos_d     = pos_q + PosW'(1);
    emitted_d = emitted_new;
    // end of block: eob unless the block is already full
    if (pos_q == PosW'(BLOCK_LEN - 1)) begin
      if (emitted_new < CntW'(BLOCK_LEN) || !b.main_vld) begin
        b.eob_vld = 1'b1;
      end else begin
        b.main_done = 1'b1;
      end
      pos_d     = '0;
      zc_d      = 4'd0;
      held_d    = 2'd0;
      emitted_d = '0;
    end
  end

  assign bundle_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_dc_q <= '0;
      pos_q     <= '0;
      zc_q      <= '0;
      held_q    <= '0;
      emitted_q <= '0;
    end else if (accept_i) begin
      prev_dc_q <= prev_dc_d;
      pos_q     <= pos_d;
      zc_q      <= zc_d;
      held_q    <= held_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

>>> hw/rtl/jbrle_checker.sv
// ----------------------------------------------------------------------------
// jbrle_assert
// port-level checks of the block run-length encoder
// ----------------------------------------------------------------------------
module jbrle_assert import jbrle_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input coef_req_t in_req_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input rle_res_t  out_res_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // stalled request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request changed while stalled");

  // a zero category is a run marker, eob or a zero dc difference, with no value bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.category == 4'd0 |->
      out_res_o.amplitude_bits == 12'd0 &&
      (out_res_o.zero_run == 4'd0 || out_res_o.zero_run == MaxRun))
    else $error("bad zero-category result");

  // amplitude fits in the category bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.category <= 4'd12 &&
      (out_res_o.amplitude_bits >> out_res_o.category) == 12'd0)
    else $error("amplitude wider than category");

endmodule

bind jpeg_block_run_length_encoder jbrle_assert u_jbrle_assert (.*);
